>>> hdl/ctgb_pkg.sv
package ctgb_pkg;

    localparam int CTGB_CAPACITY = 1024;

    localparam int OP_W    = 3;
    localparam int CH_W    = 8;
    localparam int POS_W   = 10;
    localparam int COUNT_W = 11;

    localparam logic [OP_W-1:0] OP_LEFT   = 3'd0;
    localparam logic [OP_W-1:0] OP_RIGHT  = 3'd1;
    localparam logic [OP_W-1:0] OP_BACK   = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CH_W-1:0]  ch;
        logic [POS_W-1:0] position;
    } t_in;

    typedef struct packed {
        logic [CH_W-1:0]    read_char;
        logic               read_valid;
        logic [COUNT_W-1:0] cursor_pos;
        logic [COUNT_W-1:0] text_length;
        logic               full_res;
    } t_out;

    typedef struct packed {
        logic load;
        logic commit;
    } t_cmd;

endpackage

>>> hdl/ctgb_stream_if.sv
interface ctgb_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/ctgb_ctrl.sv
module ctgb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output ctgb_pkg::t_cmd   o_cmd
);
    import ctgb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_cmd.load   = i_in_valid && (r_state == S_IDLE);
        o_cmd.commit = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
        o_out_valid  = r_out_valid;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        priority if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> hdl/ctgb_dp.sv
module ctgb_dp #(
    parameter int CAPACITY = ctgb_pkg::CTGB_CAPACITY
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ctgb_pkg::t_cmd i_cmd,
    input  ctgb_pkg::t_in  i_in,
    output ctgb_pkg::t_out o_res
);
    import ctgb_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int XW = CW + COUNT_W + 1;
    localparam logic [CW-1:0] CAP_N = CW'(CAPACITY);
    localparam logic [CW:0]   CAP_S = (CW + 1)'(CAPACITY);

    logic [CH_W-1:0] r_left_mem  [CAPACITY];
    logic [CH_W-1:0] r_right_mem [CAPACITY];

    logic [CW-1:0]   r_lc;
    logic [CW-1:0]   r_rc;
    logic [CW-1:0]   n_lc;
    logic [CW-1:0]   n_rc;
    logic [OP_W-1:0] r_op;
    logic [CH_W-1:0] r_ch;
    logic            r_lhit;
    logic            r_rhit;
    logic [CH_W-1:0] r_lq;
    logic [CH_W-1:0] r_rq;
    t_out            r_res;

    logic [EW-1:0]   pos_e;
    logic [EW-1:0]   lc_e;
    logic [EW-1:0]   rc_e;
    logic [EW-1:0]   off;
    logic [EW-1:0]   ridx;
    logic [EW-1:0]   lc_m1;
    logic [EW-1:0]   rc_m1;
    logic            l_hit;
    logic            r_hit;
    logic [AW-1:0]   la;
    logic [AW-1:0]   ra;

    logic            lwe;
    logic            rwe;
    logic [CH_W-1:0] lwd;
    logic            full;
    logic [CW:0]     sum;
    logic [CW:0]     n_len;
    logic [XW-1:0]   lc_x;
    logic [XW-1:0]   len_x;

    always_comb begin
        pos_e = EW'(i_in.position);
        lc_e  = EW'(r_lc);
        rc_e  = EW'(r_rc);
        off   = pos_e - lc_e;
        ridx  = rc_e - EW'(1) - off;
        lc_m1 = lc_e - EW'(1);
        rc_m1 = rc_e - EW'(1);
        l_hit = (pos_e < lc_e);
        r_hit = !l_hit && (off < rc_e);
        if (i_in.op == OP_READ) begin
            la = pos_e[AW-1:0];
            ra = ridx[AW-1:0];
        end else begin
            la = lc_m1[AW-1:0];
            ra = rc_m1[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_in.op;
            r_ch   <= i_in.ch;
            r_lhit <= (i_in.op == OP_READ) && l_hit;
            r_rhit <= (i_in.op == OP_READ) && r_hit;
            r_lq   <= r_left_mem[la];
            r_rq   <= r_right_mem[ra];
        end
        if (lwe) begin
            r_left_mem[r_lc[AW-1:0]] <= lwd;
        end
        if (rwe) begin
            r_right_mem[r_rc[AW-1:0]] <= r_lq;
        end
    end

    always_comb begin
        n_lc = r_lc;
        n_rc = r_rc;
        lwe  = 1'b0;
        rwe  = 1'b0;
        lwd  = r_ch;
        full = 1'b0;
        sum  = {1'b0, r_lc} + {1'b0, r_rc};
        unique case (r_op)
            OP_LEFT: begin
                if ((r_lc != '0) && (r_rc < CAP_N)) begin
                    n_lc = r_lc - CW'(1);
                    n_rc = r_rc + CW'(1);
                    rwe  = i_cmd.commit;
                end
            end
            OP_RIGHT: begin
                if ((r_rc != '0) && (r_lc < CAP_N)) begin
                    n_rc = r_rc - CW'(1);
                    n_lc = r_lc + CW'(1);
                    lwd  = r_rq;
                    lwe  = i_cmd.commit;
                end
            end
            OP_BACK: begin
                if (r_lc != '0) begin
                    n_lc = r_lc - CW'(1);
                end
            end
            OP_INSERT: begin
                if (sum >= CAP_S) begin
                    full = 1'b1;
                end else begin
                    n_lc = r_lc + CW'(1);
                    lwe  = i_cmd.commit;
                end
            end
            default: begin
                n_lc = r_lc;
            end
        endcase
        n_len = {1'b0, n_lc} + {1'b0, n_rc};
        lc_x  = XW'(n_lc);
        len_x = XW'(n_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc <= '0;
            r_rc <= '0;
        end else if (i_cmd.commit) begin
            r_lc <= n_lc;
            r_rc <= n_rc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res.read_char   <= r_lhit ? r_lq : (r_rhit ? r_rq : '0);
            r_res.read_valid  <= r_lhit || r_rhit;
            r_res.cursor_pos  <= lc_x[COUNT_W-1:0];
            r_res.text_length <= len_x[COUNT_W-1:0];
            r_res.full_res    <= full;
        end
    end

    assign o_res = r_res;

endmodule

>>> hdl/cursor_text_gap_buffer.sv
// Line-edit buffer with a cursor, held as two stacks in synchronous memories:
// the text left of the cursor and the text right of it (top is the character
// just after the cursor). Commands: cursor left, cursor right, backspace,
// insert before the cursor, and read at a text position; each command gives
// one result with the read character, a read-valid flag, the cursor position,
// the text length and a flag for an insert dropped at full capacity. A command
// is first loaded, which registers it and reads the stack tops (or the
// requested position) from the memories; its commit then writes the moved or
// inserted character and registers the result. The next command is accepted
// the cycle after the commit, while the result still waits; if the previous
// result is untaken, the commit waits for it. No clearing pass after reset.
module cursor_text_gap_buffer #(
    parameter int CAPACITY = ctgb_pkg::CTGB_CAPACITY
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ctgb_stream_if.sink   i_cmd,
    ctgb_stream_if.source o_res
);
    import ctgb_pkg::*;

    t_cmd w_cmd;
    t_in  w_in;
    t_out w_res;
    logic w_in_ready;
    logic w_out_valid;

    assign w_in = i_cmd.data;

    ctgb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    ctgb_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_in    (w_in),
        .o_res   (w_res)
    );

    assign i_cmd.ready = w_in_ready;
    assign o_res.valid = w_out_valid;
    assign o_res.data  = w_res;

    a_no_load_and_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.load && w_cmd.commit))
        else $error("load and commit in the same cycle");

    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> !w_in_ready)
        else $error("transfer accepted while a command is in flight");

    a_full_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_valid && w_res.full_res) |-> (w_res.text_length == COUNT_W'(CAPACITY)))
        else $error("insert dropped below capacity");

endmodule
